// ===== design/ctmr_pkg.sv =====
package ctmr_pkg;

    localparam int DATA_W      = 16;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = APB_ADDR_W - 2;
    localparam int DIVIDEND_W  = 2 * DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);

    localparam logic [REG_IDX_W-1:0] REG_RAY_LENGTH  = 1'b0;
    localparam logic [DATA_W-1:0]    RAY_LENGTH_INIT = 16'd1000;
    localparam logic [DATA_W-1:0]    METRIC_MAX      = 16'hFFFF;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ACC  = 6'b000010,
        ST_SUB  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_NEXT = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        OP_PTRIM,
        OP_OTRIM,
        OP_PMEAN,
        OP_OMEAN,
        OP_PMET,
        OP_OMET
    } div_op_t;

endpackage

// ===== design/ctmr_if.sv =====
interface ctmr_in_if;
    import ctmr_pkg::*;

    logic              valid;
    logic              ready;
    logic              moved;
    logic [DATA_W-1:0] dist_a;
    logic [DATA_W-1:0] dist_b;
    logic [DATA_W-1:0] dist_c;

    modport source (output valid, output moved, output dist_a, output dist_b,
                    output dist_c, input ready);
    modport sink   (input valid, input moved, input dist_a, input dist_b,
                    input dist_c, output ready);
endinterface

interface ctmr_out_if;
    import ctmr_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] pess_radius;
    logic [DATA_W-1:0] opt_radius;
    logic [DATA_W-1:0] pess_metric;
    logic [DATA_W-1:0] opt_metric;

    modport source (output valid, output pess_radius, output opt_radius,
                    output pess_metric, output opt_metric, input ready);
    modport sink   (input valid, input pess_radius, input opt_radius,
                    input pess_metric, input opt_metric, output ready);
endinterface

// ===== design/cascaded_trimmed_mean_range_filter.sv =====
// A tick that does not close a phase block leaves ready high. A tick closing one adds a pass over the
// PHASES entries and two trim divisions; closing a run adds a pass over the SMOOTH_DEPTH entries, two
// mean and two metric divisions (metric ones skipped at zero ray_length) and any wait for the output
// register. One 32-step restoring divider does every division in turn. Throughput: one word per
// cycle while no block closes, and the next word is taken while a result waits for the receiver.
// Reset (rst_n, asynchronous, low) sets ray_length to 1000 and starts a run; buffers are unreset.
module cascaded_trimmed_mean_range_filter #(
    parameter int PHASES       = 4,
    parameter int SMOOTH_DEPTH = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    ctmr_in_if.sink                          in_ch,
    ctmr_out_if.source                       out_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ctmr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ctmr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ctmr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import ctmr_pkg::*;

    localparam int PW   = $clog2(PHASES);
    localparam int SW   = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;
    localparam int MAXN = (PHASES > SMOOTH_DEPTH) ? PHASES : SMOOTH_DEPTH;
    localparam int KW   = $clog2(MAXN);
    localparam int SUMW = DATA_W + KW;

    localparam logic [PW-1:0]        PHASE_LAST  = PW'(PHASES - 1);
    localparam logic [SW-1:0]        SMOOTH_LAST = SW'(SMOOTH_DEPTH - 1);
    localparam logic [KW-1:0]        K_PH_LAST   = KW'(PHASES - 1);
    localparam logic [KW-1:0]        K_SM_LAST   = KW'(SMOOTH_DEPTH - 1);
    localparam logic [DATA_W-1:0]    TRIM_DIV    = DATA_W'(PHASES - 1);
    localparam logic [DATA_W-1:0]    MEAN_DIV    = DATA_W'(SMOOTH_DEPTH);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST    = DIV_CNT_W'(DIVIDEND_W - 1);

    // Phase and smoothing buffers.
    logic [DATA_W-1:0] pph_mem [PHASES];
    logic [DATA_W-1:0] oph_mem [PHASES];
    logic [DATA_W-1:0] psm_mem [SMOOTH_DEPTH];
    logic [DATA_W-1:0] osm_mem [SMOOTH_DEPTH];

    state_t                  state_reg, state_next;
    div_op_t                 op_reg, op_next;
    logic [DATA_W-1:0]       ray_length_reg;
    logic                    run_active_reg, run_active_next;
    logic [PW-1:0]           phase_count_reg, phase_count_next;
    logic [SW-1:0]           smooth_count_reg, smooth_count_next;
    logic                    acc_smooth_reg, acc_smooth_next;
    logic [KW-1:0]           k_reg, k_next;
    logic [SUMW-1:0]         sum_p_reg, sum_p_next;
    logic [SUMW-1:0]         sum_o_reg, sum_o_next;
    logic [DATA_W-1:0]       ext_p_reg, ext_p_next;
    logic [DATA_W-1:0]       ext_o_reg, ext_o_next;
    logic [DATA_W-1:0]       rem_reg, rem_next;
    logic [DIVIDEND_W-1:0]   dq_reg, dq_next;
    logic [DATA_W-1:0]       divisor_reg, divisor_next;
    logic [DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DATA_W-1:0]       hold_reg, hold_next;
    logic [DATA_W-1:0]       pr_reg, pr_next;
    logic [DATA_W-1:0]       or_reg, or_next;
    logic [DATA_W-1:0]       pm_reg, pm_next;
    logic                    out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]       out_pr_reg, out_or_reg, out_pm_reg, out_om_reg;
    logic                    out_load;

    logic                    in_fire;
    logic                    cfg_wr;
    logic                    wr_phase, wr_smooth;
    logic [DATA_W-1:0]       ra, rb, rc, max3, min3;
    logic [DATA_W+1:0]       sum3;
    logic [DATA_W-1:0]       tick_pess, tick_opt;
    logic [DATA_W-1:0]       ent_p, ent_o;
    logic                    acc_last;
    logic [DATA_W:0]         rem_sh, diff;
    logic                    take;
    logic [DATA_W-1:0]       q16, q_sat;
    logic                    div_start;
    logic [DIVIDEND_W-1:0]   div_dividend;
    logic [DATA_W-1:0]       div_divisor;
    div_op_t                 div_op;

    assign in_fire     = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);

    assign cfg_wr = psel && penable && pwrite
                    && (paddr[APB_ADDR_W-1:2] == REG_RAY_LENGTH);
    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_RAY_LENGTH)
                    ? {{(APB_DATA_W - DATA_W){1'b0}}, ray_length_reg} : '0;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.pess_radius = out_pr_reg;
    assign out_ch.opt_radius  = out_or_reg;
    assign out_ch.pess_metric = out_pm_reg;
    assign out_ch.opt_metric  = out_om_reg;

    // Per-tick pair: drop the largest reading for the pessimistic value, the smallest for
    // the optimistic one, then halve.
    always_comb
    begin
        ra   = (in_ch.dist_a > ray_length_reg) ? ray_length_reg : in_ch.dist_a;
        rb   = (in_ch.dist_b > ray_length_reg) ? ray_length_reg : in_ch.dist_b;
        rc   = (in_ch.dist_c > ray_length_reg) ? ray_length_reg : in_ch.dist_c;
        sum3 = (DATA_W+2)'(ra) + (DATA_W+2)'(rb) + (DATA_W+2)'(rc);
        max3 = (ra > rb) ? ra : rb;
        max3 = (rc > max3) ? rc : max3;
        min3 = (ra < rb) ? ra : rb;
        min3 = (rc < min3) ? rc : min3;
        tick_pess = DATA_W'((sum3 - (DATA_W+2)'(max3)) >> 1);
        tick_opt  = DATA_W'((sum3 - (DATA_W+2)'(min3)) >> 1);
    end

    assign ent_p    = acc_smooth_reg ? psm_mem[k_reg[SW-1:0]] : pph_mem[k_reg[PW-1:0]];
    assign ent_o    = acc_smooth_reg ? osm_mem[k_reg[SW-1:0]] : oph_mem[k_reg[PW-1:0]];
    assign acc_last = acc_smooth_reg ? (k_reg == K_SM_LAST) : (k_reg == K_PH_LAST);

    // One restoring step of the shared divider.
    assign rem_sh = {rem_reg, dq_reg[DIVIDEND_W-1]};
    assign diff   = rem_sh - {1'b0, divisor_reg};
    assign take   = !diff[DATA_W];
    assign q16    = dq_reg[DATA_W-1:0];
    assign q_sat  = (|dq_reg[DIVIDEND_W-1:DATA_W]) ? METRIC_MAX : q16;

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        run_active_next   = run_active_reg;
        phase_count_next  = phase_count_reg;
        smooth_count_next = smooth_count_reg;
        acc_smooth_next   = acc_smooth_reg;
        k_next            = k_reg;
        sum_p_next        = sum_p_reg;
        sum_o_next        = sum_o_reg;
        ext_p_next        = ext_p_reg;
        ext_o_next        = ext_o_reg;
        rem_next          = rem_reg;
        dq_next           = dq_reg;
        divisor_next      = divisor_reg;
        cnt_next          = cnt_reg;
        hold_next         = hold_reg;
        pr_next           = pr_reg;
        or_next           = or_reg;
        pm_next           = pm_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        out_load          = 1'b0;
        wr_phase          = 1'b0;
        wr_smooth         = 1'b0;
        div_start         = 1'b0;
        div_dividend      = '0;
        div_divisor       = TRIM_DIV;
        div_op            = OP_PTRIM;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_ch.moved || run_active_reg))
                begin
                    run_active_next = 1'b1;
                    wr_phase        = 1'b1;
                    if (phase_count_reg == PHASE_LAST)
                    begin
                        phase_count_next = '0;
                        acc_smooth_next  = 1'b0;
                        k_next           = '0;
                        state_next       = ST_ACC;
                    end
                    else
                    begin
                        phase_count_next = phase_count_reg + 1'b1;
                    end
                end
            end
            ST_ACC:
            begin
                if (k_reg == '0)
                begin
                    sum_p_next = SUMW'(ent_p);
                    sum_o_next = SUMW'(ent_o);
                    ext_p_next = ent_p;
                    ext_o_next = ent_o;
                end
                else
                begin
                    sum_p_next = sum_p_reg + SUMW'(ent_p);
                    sum_o_next = sum_o_reg + SUMW'(ent_o);
                    ext_p_next = (ent_p > ext_p_reg) ? ent_p : ext_p_reg;
                    ext_o_next = (ent_o < ext_o_reg) ? ent_o : ext_o_reg;
                end
                if (acc_last)
                begin
                    state_next = ST_SUB;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_SUB:
            begin
                div_start = 1'b1;
                if (acc_smooth_reg)
                begin
                    div_dividend = DIVIDEND_W'(sum_p_reg);
                    div_divisor  = MEAN_DIV;
                    div_op       = OP_PMEAN;
                end
                else
                begin
                    div_dividend = DIVIDEND_W'(sum_p_reg - SUMW'(ext_p_reg));
                    div_divisor  = TRIM_DIV;
                    div_op       = OP_PTRIM;
                    sum_o_next   = sum_o_reg - SUMW'(ext_o_reg);
                end
            end
            ST_DIV:
            begin
                rem_next = take ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                dq_next  = {dq_reg[DIVIDEND_W-2:0], take};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                case (op_reg)
                    OP_PTRIM:
                    begin
                        hold_next    = q16;
                        div_start    = 1'b1;
                        div_dividend = DIVIDEND_W'(sum_o_reg);
                        div_divisor  = TRIM_DIV;
                        div_op       = OP_OTRIM;
                    end
                    OP_OTRIM:
                    begin
                        wr_smooth = 1'b1;
                        if (smooth_count_reg == SMOOTH_LAST)
                        begin
                            smooth_count_next = '0;
                            acc_smooth_next   = 1'b1;
                            k_next            = '0;
                            state_next        = ST_ACC;
                        end
                        else
                        begin
                            smooth_count_next = smooth_count_reg + 1'b1;
                            state_next        = ST_IDLE;
                        end
                    end
                    OP_PMEAN:
                    begin
                        pr_next      = q16;
                        div_start    = 1'b1;
                        div_dividend = DIVIDEND_W'(sum_o_reg);
                        div_divisor  = MEAN_DIV;
                        div_op       = OP_OMEAN;
                    end
                    OP_OMEAN:
                    begin
                        or_next = q16;
                        // A zero ray length gives zero metrics without dividing.
                        if (ray_length_reg == '0)
                        begin
                            pm_next    = '0;
                            hold_next  = '0;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            div_start    = 1'b1;
                            div_dividend = {pr_reg, {DATA_W{1'b0}}};
                            div_divisor  = ray_length_reg;
                            div_op       = OP_PMET;
                        end
                    end
                    OP_PMET:
                    begin
                        pm_next      = q_sat;
                        div_start    = 1'b1;
                        div_dividend = {or_reg, {DATA_W{1'b0}}};
                        div_divisor  = ray_length_reg;
                        div_op       = OP_OMET;
                    end
                    OP_OMET:
                    begin
                        hold_next  = q_sat;
                        state_next = ST_EMIT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load        = 1'b1;
                    out_valid_next  = 1'b1;
                    run_active_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (div_start)
        begin
            dq_next      = div_dividend;
            rem_next     = '0;
            divisor_next = div_divisor;
            cnt_next     = '0;
            op_next      = div_op;
            state_next   = ST_DIV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            op_reg           <= OP_PTRIM;
            ray_length_reg   <= RAY_LENGTH_INIT;
            run_active_reg   <= 1'b1;
            phase_count_reg  <= '0;
            smooth_count_reg <= '0;
            acc_smooth_reg   <= 1'b0;
            k_reg            <= '0;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            run_active_reg   <= run_active_next;
            phase_count_reg  <= phase_count_next;
            smooth_count_reg <= smooth_count_next;
            acc_smooth_reg   <= acc_smooth_next;
            k_reg            <= k_next;
            cnt_reg          <= cnt_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_wr)
            begin
                ray_length_reg <= pwdata[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_p_reg   <= sum_p_next;
        sum_o_reg   <= sum_o_next;
        ext_p_reg   <= ext_p_next;
        ext_o_reg   <= ext_o_next;
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        divisor_reg <= divisor_next;
        hold_reg    <= hold_next;
        pr_reg      <= pr_next;
        or_reg      <= or_next;
        pm_reg      <= pm_next;
        if (out_load)
        begin
            out_pr_reg <= pr_reg;
            out_or_reg <= or_reg;
            out_pm_reg <= pm_reg;
            out_om_reg <= hold_reg;
        end
        if (wr_phase)
        begin
            pph_mem[phase_count_reg] <= tick_pess;
            oph_mem[phase_count_reg] <= tick_opt;
        end
        if (wr_smooth)
        begin
            psm_mem[smooth_count_reg] <= hold_reg;
            osm_mem[smooth_count_reg] <= q16;
        end
    end

    // A result only appears as its run closes.
    a_result_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> !run_active_reg)
        else $error("result raised while the run is still active");

    // Every pessimistic value is at most its optimistic partner, so the order survives the
    // trimmed and plain means.
    a_radius_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_pr_reg <= out_or_reg))
        else $error("pessimistic radius exceeds optimistic radius");

    a_phase_close: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_ch.moved || run_active_reg) && (phase_count_reg == PHASE_LAST))
        |=> (state_reg == ST_ACC))
        else $error("closing tick of a phase block did not start accumulation");

    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !in_ch.moved && !run_active_reg)
        |=> ($stable(phase_count_reg) && $stable(smooth_count_reg) && !run_active_reg))
        else $error("idle tick changed the filter state");

endmodule
